@@ rtl/iirlp_pkg.sv @@
// Shared constants, payload types and state codes for the multichannel IIR low-pass unit.
`default_nettype none
package iirlp_pkg;

  localparam int ORDER     = 3;
  localparam int CHANNELS  = 6;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAPS      = 2 * ORDER + 1;
  localparam int TAP_W     = $clog2(TAPS);

  localparam int COEF_COUNT = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int COEF_W     = 24;
  localparam int SAMPLE_W   = 16;
  localparam int HIST_W     = 24;
  localparam int OP_W       = 24;
  localparam int PROD_W     = COEF_W + OP_W;
  localparam int ACC_W      = PROD_W + 4;

  localparam logic [CFG_IDX_W-1:0] REG_FEED_COEF_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COEF_1 = 3'd4;

  localparam logic [COEF_W-1:0] FEED_COEF_0_RESET = 24'd1048576;

  typedef struct packed {
    logic [2:0]                 channel;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                 out_channel;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } out_item_t;

  typedef logic [ORDER-1:0][SAMPLE_W-1:0] xrow_t;
  typedef logic [ORDER-1:0][HIST_W-1:0]   yrow_t;

  typedef struct packed {
    xrow_t xh;
    yrow_t yh;
  } hist_row_t;

  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] addr;
    hist_row_t       row;
  } hist_wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_LAST,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

@@ rtl/iirlp_hist_mem.sv @@
// Per-channel delay-line memory with row valid bits; unwritten rows read as zero.
`default_nettype none
module iirlp_hist_mem (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    rd_en,
  input  wire [iirlp_pkg::CH_W-1:0] rd_addr,
  output iirlp_pkg::hist_row_t   rd_row,
  input  iirlp_pkg::hist_wr_t    wr
);
  import iirlp_pkg::*;

  hist_row_t             mem [CHANNELS];
  hist_row_t             rd_q;
  logic                  rd_vld;
  logic [CHANNELS-1:0]   row_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.row;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= row_vld[rd_addr];
      end
      if (wr.en) begin
        row_vld[wr.addr] <= 1'b1;
      end
    end
  end

  assign rd_row = rd_vld ? rd_q : '0;

endmodule
`default_nettype wire

@@ rtl/multichannel_iir_lowpass_unit.sv @@
// Top level of the multichannel direct-form I IIR low-pass unit.
// Each transaction carries a channel and a signed sample and yields one filtered
// result (zero for a channel at or above CHANNELS, which skips the taps). An item
// is taken only in S_IDLE, which issues the row read; then a single shared 24x24
// multiplier walks the 2*ORDER+1 taps one per cycle, S_LAST drains the
// accumulator, and S_FIN, once the output register is free, rounds, loads it and
// writes the updated row back. The output register lets the next item be taken
// while a result still waits. Delay lines start at zero after reset with no clearing
// pass. Coefficients must be written only while the unit is idle (not enforced).
`default_nettype none
module multichannel_iir_lowpass_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  iirlp_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output iirlp_pkg::out_item_t             out_data,
  input  wire                              cfg_we,
  input  wire [iirlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [iirlp_pkg::COEF_W-1:0]      cfg_data
);
  import iirlp_pkg::*;

  state_t                    state;
  state_t                    state_next;
  logic [COEF_W-1:0]         coef [COEF_COUNT];
  in_item_t                  item;
  logic                      skip;
  logic [TAP_W-1:0]          tap;
  logic signed [PROD_W-1:0]  prod;
  logic                      prod_vld;
  logic                      prod_neg;
  logic signed [ACC_W-1:0]   acc;

  logic                      accept;
  logic                      in_range;
  logic                      out_free;
  logic                      fin_load;
  hist_row_t                 rd_row;
  hist_wr_t                  wr;

  logic signed [COEF_W-1:0]  coef_arr [TAPS];
  logic signed [OP_W-1:0]    op_arr   [TAPS];
  logic                      neg_arr  [TAPS];
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   y_sum;
  logic signed [ACC_W-1:0]   r_sum;
  logic signed [ACC_W-21:0]  y_sh;
  logic signed [ACC_W-29:0]  r_sh;
  logic signed [HIST_W-1:0]  y_new;
  logic signed [SAMPLE_W-1:0] r_new;
  logic                      y_clip;
  logic                      r_clip;
  hist_row_t                 row_new;

  assign in_range = (in_data.channel < CHANNELS);
  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;

  iirlp_hist_mem u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && in_range),
    .rd_addr (in_data.channel[CH_W-1:0]),
    .rd_row  (rd_row),
    .wr      (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEF_COUNT; i++) begin
        coef[i] <= '0;
      end
      coef[REG_FEED_COEF_0] <= FEED_COEF_0_RESET;
    end else if (cfg_we && (cfg_index < COEF_COUNT)) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      if (t == 0) begin
        coef_arr[t] = $signed(coef[0]);
        op_arr[t]   = $signed({item.sample, 8'b0});
        neg_arr[t]  = 1'b0;
      end else if (t <= ORDER) begin
        coef_arr[t] = $signed(coef[t]);
        op_arr[t]   = $signed({rd_row.xh[t-1], 8'b0});
        neg_arr[t]  = 1'b0;
      end else begin
        coef_arr[t] = $signed(coef[int'(REG_BACK_COEF_1) + t - ORDER - 1]);
        op_arr[t]   = $signed(rd_row.yh[t-ORDER-1]);
        neg_arr[t]  = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = in_range ? S_MAC : S_FIN;
        end
      end
      S_MAC: begin
        if (tap == TAP_W'(TAPS - 1)) begin
          state_next = S_LAST;
        end
      end
      S_LAST: state_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    fin_load = 1'b0;
    case (state)
      S_IDLE:  in_stall = 1'b0;
      S_FIN:   fin_load = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else if (state == S_MAC) begin
      prod_vld <= 1'b1;
    end else begin
      prod_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
      skip <= !in_range;
      tap  <= '0;
      acc  <= '0;
    end else begin
      if (state == S_MAC) begin
        prod     <= coef_arr[tap] * op_arr[tap];
        prod_neg <= neg_arr[tap];
        tap      <= tap + TAP_W'(1);
      end
      if (prod_vld) begin
        acc <= prod_neg ? acc - prod_ext : acc + prod_ext;
      end
    end
  end

  assign y_sum = acc + (ACC_W'(1) <<< 19);
  assign r_sum = acc + (ACC_W'(1) <<< 27);
  assign y_sh  = y_sum[ACC_W-1:20];
  assign r_sh  = r_sum[ACC_W-1:28];

  always_comb begin
    y_clip = 1'b0;
    r_clip = 1'b0;
    if (y_sh > (ACC_W-20)'(8388607)) begin
      y_new  = 24'sh7FFFFF;
      y_clip = 1'b1;
    end else if (y_sh < -(ACC_W-20)'(8388608)) begin
      y_new  = 24'sh800000;
      y_clip = 1'b1;
    end else begin
      y_new = y_sh[HIST_W-1:0];
    end
    if (r_sh > (ACC_W-28)'(32767)) begin
      r_new  = 16'sh7FFF;
      r_clip = 1'b1;
    end else if (r_sh < -(ACC_W-28)'(32768)) begin
      r_new  = 16'sh8000;
      r_clip = 1'b1;
    end else begin
      r_new = r_sh[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    row_new.xh[0] = item.sample;
    row_new.yh[0] = y_new;
    for (int k = 1; k < ORDER; k++) begin
      row_new.xh[k] = rd_row.xh[k-1];
      row_new.yh[k] = rd_row.yh[k-1];
    end
    wr.en   = fin_load && !skip;
    wr.addr = item.channel[CH_W-1:0];
    wr.row  = row_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_data.out_channel <= item.channel;
      out_data.filtered    <= skip ? '0 : r_new;
      out_data.clipped     <= skip ? 1'b0 : (y_clip || r_clip);
    end
  end

endmodule
`default_nettype wire

@@ test/tb_multichannel_iir_lowpass_unit.sv @@
// Testbench for the multichannel IIR low-pass unit: random and directed traffic checked against a predictor.
`timescale 1ns / 100ps

import iirlp_pkg::*;

class iir_scoreboard;
  logic signed [COEF_W-1:0]   coef [COEF_COUNT];
  logic signed [SAMPLE_W-1:0] x_hist [8][ORDER];
  logic signed [HIST_W-1:0]   y_hist [8][ORDER];
  out_item_t                  expected_q [$];
  int                         errors;

  function new();
    foreach (coef[i]) coef[i] = '0;
    coef[REG_FEED_COEF_0] = FEED_COEF_0_RESET;
    foreach (x_hist[c, k]) begin
      x_hist[c][k] = '0;
      y_hist[c][k] = '0;
    end
    errors = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void write_coef(int unsigned idx, logic [COEF_W-1:0] val);
    if (idx < COEF_COUNT) coef[idx] = val;
  endfunction

  task report(string msg);
    if (errors < 100) $display("mismatch: %s", msg);
    errors++;
  endtask

  // Run one direct-form I step on the channel's delay lines.
  function void note_input(in_item_t it);
    longint    acc;
    longint    y_q8;
    longint    res;
    bit        clip;
    int        ch;
    out_item_t e;
    e.out_channel = it.channel;
    e.filtered    = '0;
    e.clipped     = 1'b0;
    if (it.channel < CHANNELS) begin
      ch   = it.channel;
      clip = 1'b0;
      acc  = longint'(coef[REG_FEED_COEF_0]) * longint'(it.sample) * 256;
      for (int k = 1; k <= ORDER; k++) begin
        acc += longint'(coef[REG_FEED_COEF_0 + k]) * longint'(x_hist[ch][k-1]) * 256;
        acc -= longint'(coef[REG_BACK_COEF_1 + k - 1]) * longint'(y_hist[ch][k-1]);
      end
      y_q8 = (acc + (longint'(1) <<< 19)) >>> 20;
      if (y_q8 > 64'sd8388607) begin
        y_q8 = 64'sd8388607;
        clip = 1'b1;
      end
      if (y_q8 < -64'sd8388608) begin
        y_q8 = -64'sd8388608;
        clip = 1'b1;
      end
      res = (acc + (longint'(1) <<< 27)) >>> 28;
      if (res > 64'sd32767) begin
        res  = 64'sd32767;
        clip = 1'b1;
      end
      if (res < -64'sd32768) begin
        res  = -64'sd32768;
        clip = 1'b1;
      end
      for (int k = ORDER - 1; k > 0; k--) begin
        x_hist[ch][k] = x_hist[ch][k-1];
        y_hist[ch][k] = y_hist[ch][k-1];
      end
      x_hist[ch][0] = it.sample;
      y_hist[ch][0] = y_q8[HIST_W-1:0];
      e.filtered    = res[SAMPLE_W-1:0];
      e.clipped     = clip;
    end
    expected_q.push_back(e);
  endfunction

  task check_result(out_item_t got);
    out_item_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result ch=%0d filtered=%0d clipped=%0b",
                       got.out_channel, got.filtered, got.clipped));
    end else begin
      e = expected_q.pop_front();
      if (got.out_channel !== e.out_channel || got.filtered !== e.filtered ||
          got.clipped !== e.clipped)
        report($sformatf("ch %0d/%0d filtered %0d/%0d clipped %0b/%0b (got/exp)",
                         got.out_channel, e.out_channel, got.filtered, e.filtered,
                         got.clipped, e.clipped));
    end
  endtask
endclass

module tb_multichannel_iir_lowpass_unit;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_COEF_1 = REG_FEED_COEF_0 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_COEF_2 = REG_FEED_COEF_0 + 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_COEF_3 = REG_FEED_COEF_0 + 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COEF_2 = REG_BACK_COEF_1 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COEF_3 = REG_BACK_COEF_1 + 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = CFG_IDX_W'(COEF_COUNT);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 127;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data  = '0;

  logic [COEF_W-1:0] coef_set [COEF_COUNT];
  bit                calm = 1'b0;
  int                idle_cycles = 0;
  iir_scoreboard     sb = new();

  multichannel_iir_lowpass_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : drain
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(out_data);
      if (burst > 0) begin
        burst--;
        if (burst == 0) out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 11);
      end
    end
  end

  function automatic in_item_t mk(logic [2:0] ch, logic [SAMPLE_W-1:0] s);
    in_item_t it;
    it.channel = ch;
    it.sample  = s;
    return it;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Hold valid across back-to-back transactions; drop it only for a gap or a drain wait.
  task automatic send_item(in_item_t it, bit hold);
    if (hold) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (sb.pending() != 0);
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_coef(idx, val);
  endtask

  task automatic load_coef_set();
    for (int i = 0; i < COEF_COUNT; i++) write_reg(CFG_IDX_W'(i), coef_set[i]);
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, COEF_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic fill_coef_set(int style);
    case (style)
      0: foreach (coef_set[i]) coef_set[i] = COEF_W'($urandom);
      1: begin
        coef_set[REG_FEED_COEF_0] = COEF_W'(18979);
        coef_set[REG_FEED_COEF_1] = COEF_W'(56937);
        coef_set[REG_FEED_COEF_2] = COEF_W'(56937);
        coef_set[REG_FEED_COEF_3] = COEF_W'(18979);
        coef_set[REG_BACK_COEF_1] = COEF_W'(-1845494);
        coef_set[REG_BACK_COEF_2] = COEF_W'(1240354);
        coef_set[REG_BACK_COEF_3] = COEF_W'(-291612);
      end
      2: foreach (coef_set[i]) coef_set[i] = COEF_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      default: begin
        foreach (coef_set[i]) coef_set[i] = '0;
        coef_set[REG_FEED_COEF_0] = FEED_COEF_0_RESET;
      end
    endcase
  endtask

  initial begin : stimulus
    logic [2:0] ch;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_item(mk(3'd0, 16'h7FFF), 1'b0);
    send_item(mk(3'd1, 16'h8000), 1'b0);
    send_item(mk(3'd2, 16'h0000), 1'b0);
    send_item(mk(3'd3, 16'h0001), 1'b0);
    send_item(mk(3'd4, 16'hFFFF), 1'b0);
    send_item(mk(3'd5, 16'h5555), 1'b0);
    send_item(mk(3'd6, 16'h1234), 1'b0);
    send_item(mk(3'd7, 16'hFFFF), 1'b0);
    send_item(mk(3'd0, 16'hAAAA), 1'b0);
    send_item(mk(3'd0, 16'h8000), 1'b0);

    wait_idle();
    foreach (coef_set[i]) coef_set[i] = 24'h7FFFFF;
    load_coef_set();
    send_item(mk(3'd0, 16'h7FFF), 1'b0);
    send_item(mk(3'd0, 16'h7FFF), 1'b0);
    send_item(mk(3'd1, 16'h8000), 1'b0);
    send_item(mk(3'd1, 16'h8000), 1'b0);
    send_item(mk(3'd2, 16'h0001), 1'b0);
    send_item(mk(3'd7, 16'h7FFF), 1'b0);

    wait_idle();
    foreach (coef_set[i]) coef_set[i] = 24'h800000;
    write_reg(REG_UNUSED, 24'h000000);
    load_coef_set();
    send_item(mk(3'd3, 16'h8000), 1'b0);
    send_item(mk(3'd3, 16'h8000), 1'b0);
    send_item(mk(3'd4, 16'h7FFF), 1'b0);
    send_item(mk(3'd5, 16'hFFFF), 1'b1);
    send_item(mk(3'd6, 16'h8000), 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      calm = (p % 4 == 3) || (p >= PHASES - 2);
      fill_coef_set(p % 4);
      load_coef_set();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 15) == 0) ch = 3'($urandom_range(CHANNELS, 7));
        else ch = 3'($urandom_range(0, CHANNELS - 1));
        send_item(mk(ch, pick_sample()), !calm && $urandom_range(0, 49) == 0);
      end
    end

    wait_idle();
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
